// File: hdl/observer_feedback_or_iir_controller_defines.svh
// ---------------------------------------------------------------------------
// Controller assertion macros
// Shared property wrappers, clocked on clk_i and held off during reset
// ---------------------------------------------------------------------------
`ifndef OBSERVER_FEEDBACK_OR_IIR_CONTROLLER_DEFINES_SVH
`define OBSERVER_FEEDBACK_OR_IIR_CONTROLLER_DEFINES_SVH

// consequent checked in the same cycle
`define OFIC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define OFIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ofic_pkg.sv
// ---------------------------------------------------------------------------
// Controller package
// Fixed-point constants, micro-op encoding and status types
// ---------------------------------------------------------------------------
package ofic_pkg;

  localparam int unsigned SIG_FRAC     = 16;
  localparam int unsigned COEF_FRAC    = 24;
  localparam int unsigned FILTER_ORDER = 5;
  localparam int unsigned NUM_COEF     = 32;

  // request command codes
  typedef enum logic [2:0] {
    CMD_SAMPLE  = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_LOAD    = 3'd3,
    CMD_SET_REF = 3'd4
  } cmd_e;

  // control modes
  localparam logic [2:0] MODE_IIR       = 3'd0;
  localparam logic [2:0] MODE_PRED      = 3'd1;
  localparam logic [2:0] MODE_PRED_INTG = 3'd3;

  // configuration register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_PERIOD    = 3'd1;
  localparam logic [2:0] REG_OFFSET    = 3'd2;
  localparam logic [2:0] REG_MINIMUM   = 3'd3;
  localparam logic [2:0] REG_MAXIMUM   = 3'd4;
  localparam logic [2:0] REG_TARGET    = 3'd5;
  localparam logic [2:0] REG_INCREMENT = 3'd6;

  // coefficient table slots
  localparam logic [4:0] CI_B0  = 5'd0;
  localparam logic [4:0] CI_B1  = 5'd1;
  localparam logic [4:0] CI_B2  = 5'd2;
  localparam logic [4:0] CI_B3  = 5'd3;
  localparam logic [4:0] CI_B4  = 5'd4;
  localparam logic [4:0] CI_B5  = 5'd5;
  localparam logic [4:0] CI_A1  = 5'd7;
  localparam logic [4:0] CI_A2  = 5'd8;
  localparam logic [4:0] CI_A3  = 5'd9;
  localparam logic [4:0] CI_A4  = 5'd10;
  localparam logic [4:0] CI_A5  = 5'd11;
  localparam logic [4:0] CI_A11 = 5'd16;
  localparam logic [4:0] CI_A12 = 5'd17;
  localparam logic [4:0] CI_A21 = 5'd18;
  localparam logic [4:0] CI_A22 = 5'd19;
  localparam logic [4:0] CI_BB1 = 5'd20;
  localparam logic [4:0] CI_BB2 = 5'd21;
  localparam logic [4:0] CI_C1  = 5'd22;
  localparam logic [4:0] CI_C2  = 5'd23;
  localparam logic [4:0] CI_D   = 5'd24;
  localparam logic [4:0] CI_L1  = 5'd25;
  localparam logic [4:0] CI_L2  = 5'd26;
  localparam logic [4:0] CI_K1  = 5'd27;
  localparam logic [4:0] CI_K2  = 5'd28;
  localparam logic [4:0] CI_KI  = 5'd29;
  localparam logic [4:0] CI_KR  = 5'd30;

  // operand and destination selects
  typedef enum logic [3:0] {
    SEL_ZERO, SEL_MEAS, SEL_REF, SEL_E0, SEL_E1, SEL_INTEG, SEL_LASTP,
    SEL_LASTC, SEL_X, SEL_INN, SEL_YV, SEL_D0, SEL_D1, SEL_DSH
  } sel_e;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_LDS, ACC_LDP, ACC_ADDP, ACC_SUBP, ACC_ADDS, ACC_SUBS
  } acc_e;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_START, ACT_STOP, ACT_DRIVE, ACT_LOAD_COEF, ACT_SET_REF
  } act_e;

  typedef enum logic {A_COEF, A_PERIOD} asel_e;

  typedef struct packed {
    logic       mul_en;
    asel_e      a_sel;
    logic [4:0] coef;
    sel_e       b_sel;
    acc_e       acc;
    sel_e       src;
    sel_e       dst;
    act_e       act;
  } uop_t;

  typedef struct packed {
    logic       accept;
    logic       out_load;
    uop_t       uop;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       stop_eq;
  } status_t;

endpackage

// File: hdl/ofic_ctrl.sv
// ---------------------------------------------------------------------------
// Controller sequencer
// One-hot state machine stepping micro-op blocks for each request
// ---------------------------------------------------------------------------
module ofic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        command_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  ofic_pkg::status_t status_i,
  output ofic_pkg::ctrl_t   ctrl_o
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_ACT   = 10'b0000000010,
    ST_START = 10'b0000000100,
    ST_STOP  = 10'b0000001000,
    ST_IIR   = 10'b0000010000,
    ST_INTEG = 10'b0000100000,
    ST_FB    = 10'b0001000000,
    ST_PRED  = 10'b0010000000,
    ST_INNOV = 10'b0100000000,
    ST_RESP  = 10'b1000000000
  } state_e;

  localparam logic [4:0] LAST_IIR   = 5'd20;
  localparam logic [4:0] LAST_INTEG = 5'd3;
  localparam logic [4:0] LAST_FB    = 5'd5;
  localparam logic [4:0] LAST_PRED  = 5'd6;
  localparam logic [4:0] LAST_INNOV = 5'd9;
  localparam logic [4:0] LAST_START = 5'd3;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  logic [2:0] cmd_q;
  logic       out_valid_q, out_valid_d;
  logic       is_iir, is_pred, integ;
  logic       accept, out_load;
  ofic_pkg::uop_t uop;

  // accumulate-only micro-op
  function automatic ofic_pkg::uop_t op(ofic_pkg::acc_e a, ofic_pkg::sel_e s,
                                        ofic_pkg::sel_e d);
    ofic_pkg::uop_t u;
    u.mul_en = 1'b0;
    u.a_sel  = ofic_pkg::A_COEF;
    u.coef   = ofic_pkg::CI_B0;
    u.b_sel  = ofic_pkg::SEL_ZERO;
    u.acc    = a;
    u.src    = s;
    u.dst    = d;
    u.act    = ofic_pkg::ACT_NONE;
    return u;
  endfunction

  // coefficient multiply plus accumulate
  function automatic ofic_pkg::uop_t opm(logic [4:0] c, ofic_pkg::sel_e b,
                                         ofic_pkg::acc_e a, ofic_pkg::sel_e s,
                                         ofic_pkg::sel_e d);
    ofic_pkg::uop_t u;
    u        = op(a, s, d);
    u.mul_en = 1'b1;
    u.coef   = c;
    u.b_sel  = b;
    return u;
  endfunction

  // action only
  function automatic ofic_pkg::uop_t opa(ofic_pkg::act_e act);
    ofic_pkg::uop_t u;
    u     = op(ofic_pkg::ACC_NONE, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
    u.act = act;
    return u;
  endfunction

  // mode classes
  assign is_iir  = (status_i.mode == ofic_pkg::MODE_IIR);
  assign is_pred = (status_i.mode == ofic_pkg::MODE_PRED) ||
                   (status_i.mode == ofic_pkg::MODE_PRED_INTG);
  assign integ   = (status_i.mode >= ofic_pkg::MODE_PRED_INTG);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  // micro-op select and sequencing
  always_comb begin
    uop     = op(ofic_pkg::ACC_NONE, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
    state_d = state_q;
    step_d  = step_q + 5'd1;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (accept) begin
          case (command_i)
            ofic_pkg::CMD_SAMPLE: begin
              if (is_iir) state_d = ST_IIR;
              else if (is_pred) state_d = integ ? ST_INTEG : ST_FB;
              else state_d = ST_INNOV;
            end
            ofic_pkg::CMD_START: state_d = ST_START;
            ofic_pkg::CMD_STOP:  state_d = ST_STOP;
            default:             state_d = ST_ACT;
          endcase
        end
      end
      ST_ACT: begin
        if (cmd_q == ofic_pkg::CMD_LOAD) uop = opa(ofic_pkg::ACT_LOAD_COEF);
        else if (cmd_q == ofic_pkg::CMD_SET_REF) uop = opa(ofic_pkg::ACT_SET_REF);
        state_d = ST_RESP;
      end
      ST_START: begin
        case (step_q)
          5'd0: uop = opa(ofic_pkg::ACT_START);
          5'd1: uop = opm(ofic_pkg::CI_KR, is_iir ? ofic_pkg::SEL_ZERO : ofic_pkg::SEL_REF,
                          ofic_pkg::ACC_NONE, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd2: uop = op(ofic_pkg::ACC_LDP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_LASTC);
          default: uop = opa(ofic_pkg::ACT_DRIVE);
        endcase
        if (step_q == LAST_START) state_d = ST_RESP;
      end
      ST_STOP: begin
        // a ramp step is followed by a drive update, a finished ramp is not
        if (step_q == 5'd0) begin
          uop = opa(ofic_pkg::ACT_STOP);
          if (status_i.stop_eq) state_d = ST_RESP;
        end else begin
          uop     = opa(ofic_pkg::ACT_DRIVE);
          state_d = ST_RESP;
        end
      end
      ST_IIR: begin
        case (step_q)
          5'd0:  uop = op(ofic_pkg::ACC_LDS, ofic_pkg::SEL_REF, ofic_pkg::SEL_ZERO);
          5'd1:  uop = op(ofic_pkg::ACC_SUBS, ofic_pkg::SEL_MEAS, ofic_pkg::SEL_X);
          5'd2:  uop = opm(ofic_pkg::CI_B0, ofic_pkg::SEL_X, ofic_pkg::ACC_LDS,
                           ofic_pkg::SEL_D0, ofic_pkg::SEL_ZERO);
          5'd3:  uop = op(ofic_pkg::ACC_ADDP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_YV);
          5'd4:  uop = opm(ofic_pkg::CI_B1, ofic_pkg::SEL_X, ofic_pkg::ACC_LDS,
                           ofic_pkg::SEL_D1, ofic_pkg::SEL_ZERO);
          5'd5:  uop = opm(ofic_pkg::CI_A1, ofic_pkg::SEL_YV, ofic_pkg::ACC_ADDP,
                           ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd6:  uop = op(ofic_pkg::ACC_SUBP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_DSH);
          5'd7:  uop = opm(ofic_pkg::CI_B2, ofic_pkg::SEL_X, ofic_pkg::ACC_LDS,
                           ofic_pkg::SEL_D1, ofic_pkg::SEL_ZERO);
          5'd8:  uop = opm(ofic_pkg::CI_A2, ofic_pkg::SEL_YV, ofic_pkg::ACC_ADDP,
                           ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd9:  uop = op(ofic_pkg::ACC_SUBP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_DSH);
          5'd10: uop = opm(ofic_pkg::CI_B3, ofic_pkg::SEL_X, ofic_pkg::ACC_LDS,
                           ofic_pkg::SEL_D1, ofic_pkg::SEL_ZERO);
          5'd11: uop = opm(ofic_pkg::CI_A3, ofic_pkg::SEL_YV, ofic_pkg::ACC_ADDP,
                           ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd12: uop = op(ofic_pkg::ACC_SUBP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_DSH);
          5'd13: uop = opm(ofic_pkg::CI_B4, ofic_pkg::SEL_X, ofic_pkg::ACC_LDS,
                           ofic_pkg::SEL_D1, ofic_pkg::SEL_ZERO);
          5'd14: uop = opm(ofic_pkg::CI_A4, ofic_pkg::SEL_YV, ofic_pkg::ACC_ADDP,
                           ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd15: uop = op(ofic_pkg::ACC_SUBP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_DSH);
          5'd16: uop = opm(ofic_pkg::CI_B5, ofic_pkg::SEL_X, ofic_pkg::ACC_LDS,
                           ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd17: uop = opm(ofic_pkg::CI_A5, ofic_pkg::SEL_YV, ofic_pkg::ACC_ADDP,
                           ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd18: uop = op(ofic_pkg::ACC_SUBP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_DSH);
          5'd19: uop = op(ofic_pkg::ACC_LDS, ofic_pkg::SEL_YV, ofic_pkg::SEL_LASTC);
          default: uop = opa(ofic_pkg::ACT_DRIVE);
        endcase
        if (step_q == LAST_IIR) state_d = ST_RESP;
      end
      ST_INTEG: begin
        case (step_q)
          5'd0: uop = op(ofic_pkg::ACC_LDS, ofic_pkg::SEL_REF, ofic_pkg::SEL_ZERO);
          5'd1: uop = op(ofic_pkg::ACC_SUBS, ofic_pkg::SEL_MEAS, ofic_pkg::SEL_X);
          5'd2: begin
            uop = opm(ofic_pkg::CI_B0, ofic_pkg::SEL_X, ofic_pkg::ACC_LDS,
                      ofic_pkg::SEL_INTEG, ofic_pkg::SEL_ZERO);
            uop.a_sel = ofic_pkg::A_PERIOD;
          end
          default: uop = op(ofic_pkg::ACC_ADDP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_INTEG);
        endcase
        if (step_q == LAST_INTEG) state_d = ST_FB;
      end
      ST_FB: begin
        case (step_q)
          5'd0: uop = opm(ofic_pkg::CI_KR, ofic_pkg::SEL_REF, ofic_pkg::ACC_NONE,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd1: uop = opm(ofic_pkg::CI_K1, ofic_pkg::SEL_E0, ofic_pkg::ACC_LDP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd2: uop = opm(ofic_pkg::CI_K2, ofic_pkg::SEL_E1, ofic_pkg::ACC_SUBP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd3: uop = opm(ofic_pkg::CI_KI, ofic_pkg::SEL_INTEG, ofic_pkg::ACC_SUBP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          // integral term only in the integrating modes
          5'd4: uop = op(integ ? ofic_pkg::ACC_ADDP : ofic_pkg::ACC_NONE,
                         ofic_pkg::SEL_ZERO, ofic_pkg::SEL_LASTC);
          default: uop = opa(ofic_pkg::ACT_DRIVE);
        endcase
        if (step_q == LAST_FB) state_d = ST_PRED;
      end
      ST_PRED: begin
        case (step_q)
          5'd0: uop = opm(ofic_pkg::CI_A11, ofic_pkg::SEL_E0, ofic_pkg::ACC_NONE,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd1: uop = opm(ofic_pkg::CI_A12, ofic_pkg::SEL_E1, ofic_pkg::ACC_LDP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd2: uop = opm(ofic_pkg::CI_BB1, ofic_pkg::SEL_LASTP, ofic_pkg::ACC_ADDP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd3: uop = opm(ofic_pkg::CI_A21, ofic_pkg::SEL_E0, ofic_pkg::ACC_ADDP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_E0);
          5'd4: uop = opm(ofic_pkg::CI_A22, ofic_pkg::SEL_E1, ofic_pkg::ACC_LDP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd5: uop = opm(ofic_pkg::CI_BB2, ofic_pkg::SEL_LASTP, ofic_pkg::ACC_ADDP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          default: uop = op(ofic_pkg::ACC_ADDP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_E1);
        endcase
        if (step_q == LAST_PRED) state_d = is_pred ? ST_INNOV : ST_RESP;
      end
      ST_INNOV: begin
        case (step_q)
          5'd0: uop = opm(ofic_pkg::CI_C1, ofic_pkg::SEL_E0, ofic_pkg::ACC_NONE,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd1: uop = opm(ofic_pkg::CI_C2, ofic_pkg::SEL_E1, ofic_pkg::ACC_LDP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd2: uop = opm(ofic_pkg::CI_D, ofic_pkg::SEL_LASTP, ofic_pkg::ACC_ADDP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_ZERO);
          5'd3: uop = op(ofic_pkg::ACC_ADDP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_X);
          5'd4: uop = op(ofic_pkg::ACC_LDS, ofic_pkg::SEL_MEAS, ofic_pkg::SEL_ZERO);
          5'd5: uop = op(ofic_pkg::ACC_SUBS, ofic_pkg::SEL_X, ofic_pkg::SEL_INN);
          5'd6: uop = opm(ofic_pkg::CI_L1, ofic_pkg::SEL_INN, ofic_pkg::ACC_LDS,
                          ofic_pkg::SEL_E0, ofic_pkg::SEL_ZERO);
          5'd7: uop = opm(ofic_pkg::CI_L2, ofic_pkg::SEL_INN, ofic_pkg::ACC_ADDP,
                          ofic_pkg::SEL_ZERO, ofic_pkg::SEL_E0);
          5'd8: uop = op(ofic_pkg::ACC_LDS, ofic_pkg::SEL_E1, ofic_pkg::SEL_ZERO);
          default: uop = op(ofic_pkg::ACC_ADDP, ofic_pkg::SEL_ZERO, ofic_pkg::SEL_E1);
        endcase
        if (step_q == LAST_INNOV) begin
          if (is_pred) state_d = ST_RESP;
          else state_d = integ ? ST_INTEG : ST_FB;
        end
      end
      ST_RESP: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_d != state_q) step_d = '0;
  end

  // output valid holds until the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (accept) cmd_q <= command_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ctrl_o.accept   = accept;
  assign ctrl_o.out_load = out_load;
  assign ctrl_o.uop      = uop;

endmodule

// File: hdl/ofic_dpath.sv
// ---------------------------------------------------------------------------
// Controller datapath
// Shared multiply-accumulate unit, state registers, drive and ramp logic
// ---------------------------------------------------------------------------
module ofic_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] measurement_i,
  input  logic signed [31:0] reference_in_i,
  input  logic [4:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  ofic_pkg::ctrl_t    ctrl_i,
  output ofic_pkg::status_t  status_o,
  output logic               drive_valid_o,
  output logic signed [31:0] drive_physical_o,
  output logic signed [31:0] drive_command_o,
  output logic               stop_done_o
);

  localparam logic signed [31:0] ONE_COEF = 32'sd1 <<< ofic_pkg::COEF_FRAC;
  localparam logic [30:0]        ONE_SIG  = 31'd1 << ofic_pkg::SIG_FRAC;

  // configuration
  logic [2:0]         mode_q;
  logic [30:0]        period_q, inc_q;
  logic signed [31:0] offset_q, dmin_q, dmax_q, tgt_q;

  // controller state
  logic signed [31:0] coef_q [ofic_pkg::NUM_COEF];
  logic signed [31:0] dly_q [ofic_pkg::FILTER_ORDER];
  logic signed [31:0] e0_q, e1_q, integ_q, ref_q, lastc_q, lastp_q;
  logic               dvalid_q, done_q;

  // working registers
  logic signed [31:0] meas_q, rin_q, cv_q, x_q, inn_q, yv_q;
  logic [4:0]         idx_q;
  logic signed [63:0] acc_q, acc_d, prod_q, prod_sh;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b, src_v, wval, cv_fix, phys_v, ramp_v;
  logic signed [64:0] prod_full;
  logic signed [63:0] drv_sum;
  logic signed [33:0] ramp_up, ramp_dn, tgt_ext;

  // outputs
  logic               ov_q, od_q;
  logic signed [31:0] op_q, oc_q;

  ofic_pkg::uop_t uop;
  assign uop = ctrl_i.uop;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (!v[63] && (|v[62:31])) return 32'sh7fffffff;
    if (v[63] && !(&v[62:31])) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sext(logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // operand select
  function automatic logic signed [31:0] pick(ofic_pkg::sel_e s,
      logic signed [31:0] meas, logic signed [31:0] rf, logic signed [31:0] e0,
      logic signed [31:0] e1, logic signed [31:0] ig, logic signed [31:0] lp,
      logic signed [31:0] lc, logic signed [31:0] x, logic signed [31:0] inn,
      logic signed [31:0] yv, logic signed [31:0] d0, logic signed [31:0] d1);
    case (s)
      ofic_pkg::SEL_MEAS:  return meas;
      ofic_pkg::SEL_REF:   return rf;
      ofic_pkg::SEL_E0:    return e0;
      ofic_pkg::SEL_E1:    return e1;
      ofic_pkg::SEL_INTEG: return ig;
      ofic_pkg::SEL_LASTP: return lp;
      ofic_pkg::SEL_LASTC: return lc;
      ofic_pkg::SEL_X:     return x;
      ofic_pkg::SEL_INN:   return inn;
      ofic_pkg::SEL_YV:    return yv;
      ofic_pkg::SEL_D0:    return d0;
      ofic_pkg::SEL_D1:    return d1;
      default:             return '0;
    endcase
  endfunction

  assign mul_b = pick(uop.b_sel, meas_q, ref_q, e0_q, e1_q, integ_q, lastp_q, lastc_q,
                      x_q, inn_q, yv_q, dly_q[0], dly_q[1]);
  assign src_v = pick(uop.src, meas_q, ref_q, e0_q, e1_q, integ_q, lastp_q, lastc_q,
                      x_q, inn_q, yv_q, dly_q[0], dly_q[1]);

  // multiplier, product rescaled with floor rounding
  assign mul_a     = (uop.a_sel == ofic_pkg::A_PERIOD) ? $signed({2'b00, period_q})
                                                       : {coef_q[uop.coef][31], coef_q[uop.coef]};
  assign prod_full = mul_a * mul_b;
  always_comb begin
    logic signed [64:0] sh;
    if (uop.a_sel == ofic_pkg::A_PERIOD) sh = prod_full >>> ofic_pkg::SIG_FRAC;
    else sh = prod_full >>> ofic_pkg::COEF_FRAC;
    prod_sh = sh[63:0];
  end

  // accumulator
  always_comb begin
    case (uop.acc)
      ofic_pkg::ACC_LDS:  acc_d = sext(src_v);
      ofic_pkg::ACC_LDP:  acc_d = prod_q;
      ofic_pkg::ACC_ADDP: acc_d = acc_q + prod_q;
      ofic_pkg::ACC_SUBP: acc_d = acc_q - prod_q;
      ofic_pkg::ACC_ADDS: acc_d = acc_q + sext(src_v);
      ofic_pkg::ACC_SUBS: acc_d = acc_q - sext(src_v);
      default:            acc_d = acc_q;
    endcase
  end
  assign wval = sat32(acc_d);

  // drive: offset, saturate, then clamp to limits
  assign drv_sum = sext(lastc_q) + sext(offset_q);
  always_comb begin
    phys_v = sat32(drv_sum);
    if (phys_v > dmax_q) phys_v = dmax_q;
    else if (phys_v < dmin_q) phys_v = dmin_q;
  end

  // soft-stop ramp step, never past the target
  assign ramp_up = {{2{lastc_q[31]}}, lastc_q} + $signed({3'b000, inc_q});
  assign ramp_dn = {{2{lastc_q[31]}}, lastc_q} - $signed({3'b000, inc_q});
  assign tgt_ext = {{2{tgt_q[31]}}, tgt_q};
  always_comb begin
    if (lastc_q < tgt_q) ramp_v = (ramp_up > tgt_ext) ? tgt_q : ramp_up[31:0];
    else ramp_v = (ramp_dn < tgt_ext) ? tgt_q : ramp_dn[31:0];
  end

  assign cv_fix = ((idx_q == ofic_pkg::CI_KR) && (cv_q == '0)) ? ONE_COEF : cv_q;

  // configuration, state and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      period_q <= ONE_SIG;
      offset_q <= '0;
      dmin_q   <= '0;
      dmax_q   <= 32'sd1 <<< ofic_pkg::SIG_FRAC;
      tgt_q    <= '0;
      inc_q    <= 31'd655;
      for (int i = 0; i < ofic_pkg::NUM_COEF; i++) begin
        coef_q[i] <= (i == int'(ofic_pkg::CI_KR)) ? ONE_COEF : '0;
      end
      for (int i = 0; i < ofic_pkg::FILTER_ORDER; i++) dly_q[i] <= '0;
      e0_q     <= '0;
      e1_q     <= '0;
      integ_q  <= '0;
      ref_q    <= '0;
      lastc_q  <= '0;
      lastp_q  <= '0;
      dvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ofic_pkg::REG_MODE:      mode_q   <= cfg_data_i[2:0];
          ofic_pkg::REG_PERIOD:    period_q <= (cfg_data_i[30:0] == '0) ? ONE_SIG
                                                                       : cfg_data_i[30:0];
          ofic_pkg::REG_OFFSET:    offset_q <= cfg_data_i;
          ofic_pkg::REG_MINIMUM:   dmin_q   <= cfg_data_i;
          ofic_pkg::REG_MAXIMUM:   dmax_q   <= cfg_data_i;
          ofic_pkg::REG_TARGET:    tgt_q    <= cfg_data_i;
          ofic_pkg::REG_INCREMENT: inc_q    <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (ctrl_i.accept) begin
        dvalid_q <= 1'b0;
        done_q   <= 1'b0;
      end
      // micro-op result write
      case (uop.dst)
        ofic_pkg::SEL_E0:    e0_q    <= wval;
        ofic_pkg::SEL_E1:    e1_q    <= wval;
        ofic_pkg::SEL_INTEG: integ_q <= wval;
        ofic_pkg::SEL_LASTC: lastc_q <= wval;
        ofic_pkg::SEL_DSH: begin
          for (int i = 0; i < ofic_pkg::FILTER_ORDER - 1; i++) dly_q[i] <= dly_q[i + 1];
          dly_q[ofic_pkg::FILTER_ORDER - 1] <= wval;
        end
        default: ;
      endcase
      // actions
      case (uop.act)
        ofic_pkg::ACT_START: begin
          ref_q   <= rin_q;
          e0_q    <= '0;
          e1_q    <= '0;
          integ_q <= '0;
          for (int i = 0; i < ofic_pkg::FILTER_ORDER; i++) dly_q[i] <= '0;
        end
        ofic_pkg::ACT_STOP: begin
          if (lastc_q == tgt_q) done_q <= 1'b1;
          else lastc_q <= ramp_v;
        end
        ofic_pkg::ACT_DRIVE: begin
          lastp_q  <= phys_v;
          dvalid_q <= 1'b1;
        end
        ofic_pkg::ACT_LOAD_COEF: begin
          coef_q[idx_q] <= cv_fix;
          if (idx_q <= ofic_pkg::CI_A5) begin
            for (int i = 0; i < ofic_pkg::FILTER_ORDER; i++) dly_q[i] <= '0;
          end else if ((idx_q >= ofic_pkg::CI_A11) && (idx_q <= ofic_pkg::CI_KR)) begin
            e0_q    <= '0;
            e1_q    <= '0;
            integ_q <= '0;
          end
        end
        ofic_pkg::ACT_SET_REF: ref_q <= rin_q;
        default: ;
      endcase
    end
  end

  // request payload, scratch and result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      meas_q <= measurement_i;
      rin_q  <= reference_in_i;
      idx_q  <= coef_index_i;
      cv_q   <= coef_value_i;
    end
    acc_q <= acc_d;
    if (uop.mul_en) prod_q <= prod_sh;
    if (uop.dst == ofic_pkg::SEL_X)   x_q   <= wval;
    if (uop.dst == ofic_pkg::SEL_INN) inn_q <= wval;
    if (uop.dst == ofic_pkg::SEL_YV)  yv_q  <= wval;
    if (ctrl_i.out_load) begin
      ov_q <= dvalid_q;
      od_q <= done_q;
      op_q <= lastp_q;
      oc_q <= lastc_q;
    end
  end

  assign status_o.mode    = mode_q;
  assign status_o.stop_eq = (lastc_q == tgt_q);

  assign drive_valid_o    = ov_q;
  assign stop_done_o      = od_q;
  assign drive_physical_o = op_q;
  assign drive_command_o  = oc_q;

endmodule

// File: hdl/observer_feedback_or_iir_controller.sv
// ---------------------------------------------------------------------------
// Observer feedback or IIR controller
// Five-mode sampled controller on one shared multiply-accumulate unit
// ---------------------------------------------------------------------------
//  channel   signals                                     handshake
//  request   command, measurement, reference_in, coef_*  in_valid_i / in_ready_o
//  result    drive_valid, drive_physical, drive_command  out_valid_o / out_ready_i
//            stop_done
//  config    cfg_index_i, cfg_data_i                      cfg_we_i, no wait
//
//  a sample steps through its micro-op sequence on the single multiplier, one
//  micro-op per cycle; other requests run shorter micro-op sequences
//  a request is taken only while the sequencer is idle; the result sits in an
//  output register so the next request may start while it waits
//  reset clears state at once, no clearing pass
// ---------------------------------------------------------------------------
`include "observer_feedback_or_iir_controller_defines.svh"

module observer_feedback_or_iir_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] measurement_i,
  input  logic signed [31:0] reference_in_i,
  input  logic [4:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               drive_valid_o,
  output logic signed [31:0] drive_physical_o,
  output logic signed [31:0] drive_command_o,
  output logic               stop_done_o
);

  ofic_pkg::ctrl_t   ctrl;
  ofic_pkg::status_t status;

  // sequencer
  ofic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // datapath
  ofic_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .measurement_i    (measurement_i),
    .reference_in_i   (reference_in_i),
    .coef_index_i     (coef_index_i),
    .coef_value_i     (coef_value_i),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .drive_valid_o    (drive_valid_o),
    .drive_physical_o (drive_physical_o),
    .drive_command_o  (drive_command_o),
    .stop_done_o      (stop_done_o)
  );

  // checks
  `OFIC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `OFIC_ASSERT_SAME(a_drive_or_done, out_valid_o, !(drive_valid_o && stop_done_o), "drive and done")
  `OFIC_ASSERT_SAME(a_load_not_idle, ctrl.out_load, !in_ready_o, "result load while idle")

endmodule
